### rtl/sgrg_pkg.sv
// ----------------------------------------------------------------------------
// Scaled glyph rectangle generator: shared package
// Payload types, controller/datapath interface types, register indexes and
// the 5x5 glyph ROM.
// ----------------------------------------------------------------------------
package sgrg_pkg;

    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 32;
    localparam int unsigned COORD_W   = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_SCALE        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPACING      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FILL_COLOUR  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd4;

    // Index of the last row and the last column of a glyph.
    localparam logic [2:0] GLYPH_LAST = 3'd4;

    typedef struct packed {
        logic [7:0]         char_code;
        logic               new_string;
        logic signed [15:0] start_x;
        logic signed [15:0] start_y;
    } t_in;

    typedef struct packed {
        logic [COORD_W-1:0] rect_left;
        logic [COORD_W-1:0] rect_top;
        logic [COORD_W-1:0] rect_right;
        logic [COORD_W-1:0] rect_bottom;
        logic [31:0]        pixel_value;
        logic               last_rect;
    } t_out;

    typedef struct packed {
        logic load;
        logic step;
        logic flush;
        logic advance;
    } t_cmd;

    typedef struct packed {
        logic kept;
        logic last_cell;
        logic pend_valid;
        logic out_free;
    } t_sts;

    // Glyph bitmap: row 0 sits in bits [24:20]; within a row bit 4 is the
    // leftmost cell. Codes without a glyph are blank.
    function automatic logic [24:0] glyph_rom(input logic [7:0] code);
        logic [24:0] g;
        g = '0;
        unique case (code)
            "a": g = {5'h00, 5'h0E, 5'h0A, 5'h0A, 5'h0F};
            "b": g = {5'h08, 5'h08, 5'h0E, 5'h0A, 5'h0E};
            "c": g = {5'h00, 5'h00, 5'h0E, 5'h08, 5'h0E};
            "d": g = {5'h02, 5'h02, 5'h0E, 5'h0A, 5'h0E};
            "e": g = {5'h0E, 5'h0A, 5'h0E, 5'h08, 5'h0E};
            "f": g = {5'h06, 5'h04, 5'h0E, 5'h04, 5'h04};
            "g": g = {5'h0E, 5'h0A, 5'h0E, 5'h02, 5'h06};
            "h": g = {5'h08, 5'h08, 5'h0E, 5'h0A, 5'h0A};
            "i": g = {5'h00, 5'h04, 5'h00, 5'h04, 5'h04};
            "k": g = {5'h0A, 5'h0C, 5'h08, 5'h0C, 5'h0A};
            "l": g = {5'h08, 5'h08, 5'h08, 5'h08, 5'h06};
            "m": g = {5'h00, 5'h00, 5'h0A, 5'h15, 5'h11};
            "n": g = {5'h00, 5'h06, 5'h0A, 5'h0A, 5'h0A};
            "o": g = {5'h00, 5'h0E, 5'h11, 5'h11, 5'h0E};
            "p": g = {5'h00, 5'h0E, 5'h0A, 5'h0E, 5'h08};
            "r": g = {5'h00, 5'h16, 5'h0C, 5'h08, 5'h08};
            "s": g = {5'h06, 5'h08, 5'h0C, 5'h02, 5'h0E};
            "t": g = {5'h04, 5'h04, 5'h0E, 5'h04, 5'h06};
            "u": g = {5'h00, 5'h00, 5'h0A, 5'h0A, 5'h0E};
            "w": g = {5'h00, 5'h11, 5'h11, 5'h15, 5'h0A};
            "y": g = {5'h0A, 5'h0A, 5'h04, 5'h04, 5'h08};
            "A": g = {5'h0E, 5'h1B, 5'h1F, 5'h11, 5'h11};
            "B": g = {5'h0E, 5'h0B, 5'h0E, 5'h0B, 5'h0E};
            "C": g = {5'h0F, 5'h10, 5'h10, 5'h10, 5'h0F};
            "D": g = {5'h1E, 5'h11, 5'h11, 5'h11, 5'h1E};
            "E": g = {5'h1F, 5'h10, 5'h1F, 5'h10, 5'h1F};
            "F": g = {5'h1C, 5'h10, 5'h1C, 5'h10, 5'h10};
            "G": g = {5'h1C, 5'h10, 5'h14, 5'h16, 5'h1C};
            "H": g = {5'h11, 5'h11, 5'h1F, 5'h11, 5'h11};
            "I": g = {5'h0E, 5'h04, 5'h04, 5'h04, 5'h0E};
            "K": g = {5'h13, 5'h16, 5'h18, 5'h16, 5'h13};
            "L": g = {5'h10, 5'h10, 5'h10, 5'h10, 5'h1F};
            "M": g = {5'h11, 5'h1B, 5'h15, 5'h11, 5'h11};
            "N": g = {5'h11, 5'h19, 5'h15, 5'h13, 5'h11};
            "O": g = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h0E};
            "P": g = {5'h1C, 5'h14, 5'h1C, 5'h10, 5'h10};
            "R": g = {5'h1C, 5'h12, 5'h1C, 5'h16, 5'h11};
            "S": g = {5'h0E, 5'h08, 5'h0E, 5'h02, 5'h0E};
            "T": g = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04};
            "U": g = {5'h11, 5'h11, 5'h11, 5'h11, 5'h1F};
            "V": g = {5'h11, 5'h1B, 5'h0A, 5'h0A, 5'h04};
            "W": g = {5'h11, 5'h11, 5'h11, 5'h15, 5'h0A};
            "X": g = {5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11};
            "Y": g = {5'h11, 5'h0A, 5'h04, 5'h04, 5'h04};
            8'h2C: g = {5'h00, 5'h00, 5'h00, 5'h02, 5'h04}; // comma
            8'h3A: g = {5'h00, 5'h04, 5'h00, 5'h04, 5'h00}; // colon
            8'h27: g = {5'h08, 5'h08, 5'h00, 5'h00, 5'h00}; // apostrophe
            8'h21: g = {5'h04, 5'h04, 5'h04, 5'h00, 5'h04}; // exclamation
            8'h2E: g = {5'h00, 5'h00, 5'h00, 5'h00, 5'h02}; // full stop
            8'h2D: g = {5'h00, 5'h00, 5'h0E, 5'h00, 5'h00}; // minus
            8'h2B: g = {5'h04, 5'h04, 5'h1F, 5'h04, 5'h04}; // plus
            "1": g = {5'h04, 5'h0C, 5'h14, 5'h04, 5'h0E};
            "2": g = {5'h0C, 5'h12, 5'h04, 5'h08, 5'h1F};
            "3": g = {5'h0E, 5'h02, 5'h0E, 5'h02, 5'h0E};
            "4": g = {5'h06, 5'h04, 5'h0A, 5'h1E, 5'h02};
            "5": g = {5'h0E, 5'h08, 5'h0E, 5'h03, 5'h0E};
            "6": g = {5'h0E, 5'h08, 5'h0E, 5'h0A, 5'h0E};
            "7": g = {5'h1F, 5'h02, 5'h1F, 5'h08, 5'h10};
            "8": g = {5'h0E, 5'h0A, 5'h0E, 5'h0A, 5'h06};
            "9": g = {5'h0E, 5'h0A, 5'h0E, 5'h02, 5'h0E};
            "0": g = {5'h0E, 5'h0A, 5'h0A, 5'h0A, 5'h0E};
            default: g = '0;
        endcase
        return g;
    endfunction

endpackage

### rtl/sgrg_ctrl.sv
// ----------------------------------------------------------------------------
// Scaled glyph rectangle generator: controller
// Sequences one character: load, a scan of the 25 glyph cells, and a final
// flush of the held rectangle, if any, together with the cursor advance.
// ----------------------------------------------------------------------------
module sgrg_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  sgrg_pkg::t_sts i_sts,
    output sgrg_pkg::t_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FLUSH
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = (r_state == S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                // A kept cell must push the held rectangle out first.
                if (!(i_sts.kept && i_sts.pend_valid && !i_sts.out_free)) begin
                    o_cmd.step = 1'b1;
                    if (i_sts.last_cell) begin
                        n_state = S_FLUSH;
                    end
                end
            end
            S_FLUSH: begin
                if (!i_sts.pend_valid) begin
                    o_cmd.advance = 1'b1;
                    n_state       = S_IDLE;
                end else if (i_sts.out_free) begin
                    o_cmd.flush   = 1'b1;
                    o_cmd.advance = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

### rtl/sgrg_datapath.sv
// ----------------------------------------------------------------------------
// Scaled glyph rectangle generator: datapath
// Configuration registers, text cursor, glyph cell walker, rectangle clamp,
// one held rectangle and the output register.
// ----------------------------------------------------------------------------
module sgrg_datapath #(
    parameter int unsigned FRAME_MAX = 4096
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    input  logic [sgrg_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [sgrg_pkg::CFG_DAT_W-1:0]   i_cfg_data,
    input  sgrg_pkg::t_in                    i_in_data,
    input  sgrg_pkg::t_cmd                   i_cmd,
    output sgrg_pkg::t_sts                   o_sts,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output sgrg_pkg::t_out                   o_out_data
);

    localparam logic signed [25:0] COL_MAX = 26'sd8388607;
    localparam logic signed [25:0] COL_MIN = -26'sd8388608;

    function automatic logic [12:0] clamp(input logic signed [25:0] v,
                                          input logic [12:0] lim);
        logic [12:0] res;
        if (v[25]) begin
            res = '0;
        end else if (v[24:0] > {12'b0, lim}) begin
            res = lim;
        end else begin
            res = v[12:0];
        end
        return res;
    endfunction

    logic [5:0]         r_scale;
    logic signed [7:0]  r_spacing;
    logic [31:0]        r_fill;
    logic [12:0]        r_fwidth;
    logic [12:0]        r_fheight;

    logic signed [23:0] r_cur_col;
    logic signed [15:0] r_cur_row;

    logic [24:0]        r_glyph;
    logic [2:0]         r_col;
    logic [2:0]         r_row;
    logic [7:0]         r_xoff;
    logic [7:0]         r_yoff;

    logic               r_pend_valid;
    sgrg_pkg::t_out     r_pend;
    logic               r_out_valid;
    sgrg_pkg::t_out     r_out;

    logic [12:0]        lim_x;
    logic [12:0]        lim_y;
    logic signed [25:0] x0;
    logic signed [25:0] x1;
    logic signed [25:0] y0;
    logic signed [25:0] y1;
    sgrg_pkg::t_out     cur_rect;
    sgrg_pkg::t_out     flush_rect;
    logic               kept;
    logic               out_free;
    logic               emit_step;
    logic [8:0]         adv_step;
    logic signed [25:0] adv;

    // Configuration registers; indexes beyond the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale   <= 6'd1;
            r_spacing <= '0;
            r_fill    <= 32'hFFFF_FFFF;
            r_fwidth  <= 13'd640;
            r_fheight <= 13'd480;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                sgrg_pkg::CFG_SCALE:        r_scale   <= i_cfg_data[5:0];
                sgrg_pkg::CFG_SPACING:      r_spacing <= i_cfg_data[7:0];
                sgrg_pkg::CFG_FILL_COLOUR:  r_fill    <= i_cfg_data;
                sgrg_pkg::CFG_FRAME_WIDTH:  r_fwidth  <= i_cfg_data[12:0];
                sgrg_pkg::CFG_FRAME_HEIGHT: r_fheight <= i_cfg_data[12:0];
                default: begin
                end
            endcase
        end
    end

    assign lim_x = ({19'b0, r_fwidth} > 32'(FRAME_MAX)) ? 13'(FRAME_MAX) : r_fwidth;
    assign lim_y = ({19'b0, r_fheight} > 32'(FRAME_MAX)) ? 13'(FRAME_MAX) : r_fheight;

    // Rectangle of the current cell.
    assign x0 = {{2{r_cur_col[23]}}, r_cur_col} + {18'b0, r_xoff};
    assign x1 = x0 + {20'b0, r_scale};
    assign y0 = {{10{r_cur_row[15]}}, r_cur_row} + {18'b0, r_yoff};
    assign y1 = y0 + {20'b0, r_scale};

    always_comb begin
        cur_rect.rect_left   = clamp(x0, lim_x);
        cur_rect.rect_right  = clamp(x1, lim_x);
        cur_rect.rect_top    = clamp(y0, lim_y);
        cur_rect.rect_bottom = clamp(y1, lim_y);
        cur_rect.pixel_value = r_fill;
        cur_rect.last_rect   = 1'b0;
    end

    // The held rectangle as it leaves at the end of a character.
    always_comb begin
        flush_rect           = r_pend;
        flush_rect.last_rect = 1'b1;
    end

    assign kept = r_glyph[24]
               && (cur_rect.rect_left < cur_rect.rect_right)
               && (cur_rect.rect_top < cur_rect.rect_bottom);

    assign out_free  = !r_out_valid || i_out_ready;
    assign emit_step = i_cmd.step && kept && r_pend_valid;

    always_comb begin
        o_sts.kept       = kept;
        o_sts.last_cell  = (r_row == sgrg_pkg::GLYPH_LAST) && (r_col == sgrg_pkg::GLYPH_LAST);
        o_sts.pend_valid = r_pend_valid;
        o_sts.out_free   = out_free;
    end

    // Cursor advance: scale * 6 + spacing, saturated to 24 bits signed.
    assign adv_step = {1'b0, r_scale, 2'b0} + {2'b0, r_scale, 1'b0};
    assign adv      = {{2{r_cur_col[23]}}, r_cur_col} + {17'b0, adv_step}
                    + {{18{r_spacing[7]}}, r_spacing};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_col <= '0;
            r_cur_row <= '0;
        end else if (i_cmd.load && i_in_data.new_string) begin
            r_cur_col <= {{8{i_in_data.start_x[15]}}, i_in_data.start_x};
            r_cur_row <= i_in_data.start_y;
        end else if (i_cmd.advance) begin
            if (adv > COL_MAX) begin
                r_cur_col <= COL_MAX[23:0];
            end else if (adv < COL_MIN) begin
                r_cur_col <= COL_MIN[23:0];
            end else begin
                r_cur_col <= adv[23:0];
            end
        end
    end

    // Cell walker: glyph shifts left one cell per step.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_glyph <= sgrg_pkg::glyph_rom(i_in_data.char_code);
            r_col   <= '0;
            r_row   <= '0;
            r_xoff  <= '0;
            r_yoff  <= {r_scale, 2'b0};
        end else if (i_cmd.step) begin
            r_glyph <= {r_glyph[23:0], 1'b0};
            if (r_col == sgrg_pkg::GLYPH_LAST) begin
                r_col  <= '0;
                r_row  <= r_row + 3'd1;
                r_xoff <= '0;
                r_yoff <= r_yoff - {2'b0, r_scale};
            end else begin
                r_col  <= r_col + 3'd1;
                r_xoff <= r_xoff + {2'b0, r_scale};
            end
        end
    end

    // Valid flags of the held rectangle and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.flush) begin
                r_pend_valid <= 1'b0;
            end else if (i_cmd.step && kept) begin
                r_pend_valid <= 1'b1;
            end
            if (emit_step || i_cmd.flush) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step && kept) begin
            r_pend <= cur_rect;
        end
        if (emit_step) begin
            r_out <= r_pend;
        end else if (i_cmd.flush) begin
            r_out <= flush_rect;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

### rtl/scaled_glyph_rect_generator_core.sv
// ----------------------------------------------------------------------------
// Scaled glyph rectangle generator
// Turns each character into the scaled, frame-clamped fill rectangles of
// its 5x5 glyph and keeps the text cursor.
// ----------------------------------------------------------------------------
// Usage. Characters arrive as requests on the input channel (i_in_*), each
// carrying a code and, with new_string set, a new cursor start position.
// Every lit glyph cell that stays non-empty after clamping to the frame
// leaves as one rectangle request on the output channel (o_out_*), row by
// row and left to right; the final rectangle of a character has last_rect
// set, and a character with nothing visible produces no request at all.
// Registers (scale, spacing, fill colour, frame width and height) are
// written through the configuration channel, which is always ready; they
// should only be changed while the block is idle.
// Timing: one glyph cell is examined per cycle while the receiver keeps up;
// a character passes through a load, a scan of its 25 cells and a flush.
// Each rectangle is held back until the next kept cell (or the end of the
// scan) shows whether it is the last one. If the receiver stalls, the scan
// pauses on a kept cell, and the flush waits, until the output register
// frees. Reset clears the cursor to the origin, returns the registers to
// their defaults and drops any request in flight.
// ----------------------------------------------------------------------------
module scaled_glyph_rect_generator_core #(
    parameter int unsigned FRAME_MAX = 4096
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [sgrg_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [sgrg_pkg::CFG_DAT_W-1:0]   i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  sgrg_pkg::t_in                    i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output sgrg_pkg::t_out                   o_out_data
);

    sgrg_pkg::t_cmd cmd;
    sgrg_pkg::t_sts sts;

    // Register writes go straight into the datapath registers, so the port never pushes back.
    assign o_cfg_ready = 1'b1;

    sgrg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    sgrg_datapath #(
        .FRAME_MAX (FRAME_MAX)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

### test/scaled_glyph_rect_generator_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Scaled glyph rectangle generator: self-checking testbench
// Character requests go in through a bursty driver and rectangle requests
// come out through a stalling receiver. A behavioural copy of the glyph
// table, the cursor and the registers works out every rectangle, and each
// one is compared field by field. Runs a directed opening, then random
// strings under several register settings, one of them with a long stall.
// ----------------------------------------------------------------------------
module scaled_glyph_rect_generator_core_tb;

    localparam int unsigned FRAME_LIMIT      = 4096;
    localparam int          ADVANCE_CELLS    = 6;
    localparam longint      COL_TOP          = 64'sd8388607;
    localparam longint      COL_BOTTOM       = -64'sd8388608;
    localparam int          SETTLE_CYCLES    = 40;
    localparam int          LONG_HOLD_CYCLES = 400;
    localparam int          CYCLE_LIMIT      = 250000;
    localparam int          RANDOM_PHASES    = 5;
    localparam int          PRESSURE_PHASE   = 2;
    localparam int          ITEMS_PER_PHASE  = 20;

    // Ways in which the receiver accepts rectangle requests.
    typedef enum int {FLOW_FREE, FLOW_COIN, FLOW_THIRD, FLOW_RARE_STALL} t_flow;

    logic                           clk         = 1'b0;
    logic                           rst_n       = 1'b0;
    logic                           cfg_valid   = 1'b0;
    logic                           o_cfg_ready;
    logic [sgrg_pkg::CFG_IDX_W-1:0] cfg_index   = '0;
    logic [sgrg_pkg::CFG_DAT_W-1:0] cfg_data    = '0;
    logic                           in_valid    = 1'b0;
    logic                           o_in_ready;
    sgrg_pkg::t_in                  in_data     = '0;
    logic                           o_out_valid;
    logic                           out_ready   = 1'b0;
    sgrg_pkg::t_out                 o_out_data;

    // Register copy, at reset values.
    logic [5:0]           scale_reg   = 6'd1;
    logic signed [7:0]    spacing_reg = 8'sd0;
    logic [31:0]          colour_reg  = 32'hFFFF_FFFF;
    logic [12:0]          width_reg   = 13'd640;
    logic [12:0]          height_reg  = 13'd480;

    // Cursor copy; reset leaves it at the origin.
    logic signed [23:0]   pen_col     = '0;
    logic signed [15:0]   pen_row     = '0;

    sgrg_pkg::t_in        chars_to_send[$];
    sgrg_pkg::t_out       rects_due[$];
    int                   chars_queued   = 0;
    int                   chars_accepted = 0;
    int                   rects_checked  = 0;
    int                   reg_writes     = 0;
    int                   settings_used  = 0;
    int                   faults         = 0;
    int                   cycle_count    = 0;

    int                   burst_left     = 1;
    int                   gap_left       = 0;
    t_flow                flow           = FLOW_FREE;
    int                   flow_left      = 0;
    int                   third_count    = 0;
    int                   hold_left      = 0;
    logic                 hold_done      = 1'b0;
    logic                 long_hold_req  = 1'b0;

    scaled_glyph_rect_generator_core #(
        .FRAME_MAX(FRAME_LIMIT)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data),
        .i_in_valid (in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(out_ready),
        .o_out_data (o_out_data)
    );

    always #5 clk = ~clk;

    // Glyph bitmaps, one byte per row with row 0 in the top byte; bit 4 of
    // each byte is the leftmost cell. Anything not listed is blank.
    function automatic logic [39:0] glyph_rows(input logic [7:0] code);
        unique case (code)
            "a": return 40'h00_0E_0A_0A_0F;
            "b": return 40'h08_08_0E_0A_0E;
            "c": return 40'h00_00_0E_08_0E;
            "d": return 40'h02_02_0E_0A_0E;
            "e": return 40'h0E_0A_0E_08_0E;
            "f": return 40'h06_04_0E_04_04;
            "g": return 40'h0E_0A_0E_02_06;
            "h": return 40'h08_08_0E_0A_0A;
            "i": return 40'h00_04_00_04_04;
            "k": return 40'h0A_0C_08_0C_0A;
            "l": return 40'h08_08_08_08_06;
            "m": return 40'h00_00_0A_15_11;
            "n": return 40'h00_06_0A_0A_0A;
            "o": return 40'h00_0E_11_11_0E;
            "p": return 40'h00_0E_0A_0E_08;
            "r": return 40'h00_16_0C_08_08;
            "s": return 40'h06_08_0C_02_0E;
            "t": return 40'h04_04_0E_04_06;
            "u": return 40'h00_00_0A_0A_0E;
            "w": return 40'h00_11_11_15_0A;
            "y": return 40'h0A_0A_04_04_08;
            "A": return 40'h0E_1B_1F_11_11;
            "B": return 40'h0E_0B_0E_0B_0E;
            "C": return 40'h0F_10_10_10_0F;
            "D": return 40'h1E_11_11_11_1E;
            "E": return 40'h1F_10_1F_10_1F;
            "F": return 40'h1C_10_1C_10_10;
            "G": return 40'h1C_10_14_16_1C;
            "H": return 40'h11_11_1F_11_11;
            "I": return 40'h0E_04_04_04_0E;
            "K": return 40'h13_16_18_16_13;
            "L": return 40'h10_10_10_10_1F;
            "M": return 40'h11_1B_15_11_11;
            "N": return 40'h11_19_15_13_11;
            "O": return 40'h0E_11_11_11_0E;
            "P": return 40'h1C_14_1C_10_10;
            "R": return 40'h1C_12_1C_16_11;
            "S": return 40'h0E_08_0E_02_0E;
            "T": return 40'h1F_04_04_04_04;
            "U": return 40'h11_11_11_11_1F;
            "V": return 40'h11_1B_0A_0A_04;
            "W": return 40'h11_11_11_15_0A;
            "X": return 40'h11_0A_04_0A_11;
            "Y": return 40'h11_0A_04_04_04;
            8'h2C: return 40'h00_00_00_02_04; // comma
            8'h3A: return 40'h00_04_00_04_00; // colon
            8'h27: return 40'h08_08_00_00_00; // apostrophe
            8'h21: return 40'h04_04_04_00_04; // exclamation mark
            8'h2E: return 40'h00_00_00_00_02; // full stop
            8'h2D: return 40'h00_00_0E_00_00; // minus
            8'h2B: return 40'h04_04_1F_04_04; // plus
            "1": return 40'h04_0C_14_04_0E;
            "2": return 40'h0C_12_04_08_1F;
            "3": return 40'h0E_02_0E_02_0E;
            "4": return 40'h06_04_0A_1E_02;
            "5": return 40'h0E_08_0E_03_0E;
            "6": return 40'h0E_08_0E_0A_0E;
            "7": return 40'h1F_02_1F_08_10;
            "8": return 40'h0E_0A_0E_0A_06;
            "9": return 40'h0E_0A_0E_02_0E;
            "0": return 40'h0E_0A_0A_0A_0E;
            default: return 40'h0;
        endcase
    endfunction

    function automatic longint clip_to_frame(input longint v, input longint hi);
        if (v < 0) return 0;
        if (v > hi) return hi;
        return v;
    endfunction

    // Works out the rectangles that one accepted character gives, queues
    // them in order and moves the cursor on.
    task automatic trace_glyph(input sgrg_pkg::t_in ch);
        logic [39:0]    rows;
        logic [7:0]     row_bits;
        longint         side, lim_x, lim_y, x0, x1, y0, y1, next_col;
        sgrg_pkg::t_out rect;
        sgrg_pkg::t_out drawn[$];
        rows  = glyph_rows(ch.char_code);
        side  = longint'(scale_reg);
        lim_x = (width_reg > FRAME_LIMIT) ? longint'(FRAME_LIMIT) : longint'(width_reg);
        lim_y = (height_reg > FRAME_LIMIT) ? longint'(FRAME_LIMIT) : longint'(height_reg);
        if (ch.new_string) begin
            pen_col = 24'(ch.start_x);
            pen_row = ch.start_y;
        end
        for (int r = 0; r < 5; r++) begin
            row_bits = rows[8*(4-r) +: 8];
            for (int c = 0; c < 5; c++) begin
                if (!row_bits[4-c]) continue;
                // Row 0 of the bitmap is the highest band of the character.
                x0 = longint'(pen_col) + c * side;
                y0 = longint'(pen_row) + (4 - r) * side;
                x1 = clip_to_frame(x0 + side, lim_x);
                y1 = clip_to_frame(y0 + side, lim_y);
                x0 = clip_to_frame(x0, lim_x);
                y0 = clip_to_frame(y0, lim_y);
                if (x0 >= x1 || y0 >= y1) continue;
                rect.rect_left   = 13'(x0);
                rect.rect_top    = 13'(y0);
                rect.rect_right  = 13'(x1);
                rect.rect_bottom = 13'(y1);
                rect.pixel_value = colour_reg;
                rect.last_rect   = 1'b0;
                drawn.push_back(rect);
            end
        end
        // Only a character that leaves something visible has a last flag.
        if (drawn.size() > 0) begin
            rect = drawn.pop_back();
            rect.last_rect = 1'b1;
            drawn.push_back(rect);
        end
        foreach (drawn[i]) rects_due.push_back(drawn[i]);
        next_col = longint'(pen_col) + side * ADVANCE_CELLS + longint'(spacing_reg);
        if (next_col > COL_TOP) next_col = COL_TOP;
        if (next_col < COL_BOTTOM) next_col = COL_BOTTOM;
        pen_col = 24'(next_col);
    endtask

    task automatic queue_char(input logic [7:0] code, input logic fresh,
                              input logic [15:0] x, input logic [15:0] y);
        sgrg_pkg::t_in ch;
        ch.char_code  = code;
        ch.new_string = fresh;
        ch.start_x    = x;
        ch.start_y    = y;
        chars_to_send.push_back(ch);
        chars_queued++;
    endtask

    // Writes one register and keeps the copy in step. The valid stays high
    // so that writes run back to back; the caller lowers it after a batch.
    task automatic write_reg(input logic [sgrg_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        if (!cfg_valid) cfg_valid <= 1'b1;
        do @(posedge clk); while (!o_cfg_ready);
        unique case (idx)
            sgrg_pkg::CFG_SCALE:        scale_reg   = val[5:0];
            sgrg_pkg::CFG_SPACING:      spacing_reg = val[7:0];
            sgrg_pkg::CFG_FILL_COLOUR:  colour_reg  = val;
            sgrg_pkg::CFG_FRAME_WIDTH:  width_reg   = val[12:0];
            sgrg_pkg::CFG_FRAME_HEIGHT: height_reg  = val[12:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    // Waits until every character has been taken and every rectangle has
    // come back, then gives a blank character time to finish its scan.
    task automatic drain();
        do @(posedge clk);
        while (chars_accepted != chars_queued || rects_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [31:0] pick_frame();
        if ($urandom_range(0, 9) < 7) return $urandom_range(16, 4096);
        case ($urandom_range(0, 4))
            0: return 32'd0;
            1: return 32'd1;
            2: return 32'd4096;
            3: return 32'd8191;
            default: return $urandom_range(4097, 8191);
        endcase
    endfunction

    // Sender: bursts of requests with idle gaps in between. The predictor
    // runs at the edge where a character request is taken.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && o_in_ready) begin
                trace_glyph(in_data);
                chars_accepted++;
            end
            if (!in_valid || o_in_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (chars_to_send.size() > 0) begin
                    in_data  <= chars_to_send.pop_front();
                    in_valid <= 1'b1;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 16);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: switches between flow patterns at random intervals, and
    // once on request holds off for a long stretch so that the block backs
    // up and stops taking character requests.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else if (long_hold_req && !hold_done) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD_CYCLES;
            out_ready <= 1'b0;
        end else begin
            if (flow_left == 0) begin
                flow      = t_flow'($urandom_range(0, 3));
                flow_left = $urandom_range(16, 96);
            end
            flow_left--;
            third_count = (third_count + 1) % 3;
            unique case (flow)
                FLOW_FREE:  out_ready <= 1'b1;
                FLOW_COIN:  out_ready <= 1'($urandom_range(0, 1));
                FLOW_THIRD: out_ready <= (third_count == 0);
                default:    out_ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    task automatic compare_field(input string label, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", label, want, got);
            faults++;
        end
    endtask

    // Checker: each rectangle request taken is matched against the oldest
    // outstanding prediction.
    always @(posedge clk) begin
        sgrg_pkg::t_out want;
        if (rst_n && o_out_valid && out_ready) begin
            if (rects_due.size() == 0) begin
                $error("rectangle request with none outstanding: %p", o_out_data);
                faults++;
            end else begin
                want = rects_due.pop_front();
                compare_field("rect_left", 32'(want.rect_left),
                              32'(o_out_data.rect_left));
                compare_field("rect_top", 32'(want.rect_top),
                              32'(o_out_data.rect_top));
                compare_field("rect_right", 32'(want.rect_right),
                              32'(o_out_data.rect_right));
                compare_field("rect_bottom", 32'(want.rect_bottom),
                              32'(o_out_data.rect_bottom));
                compare_field("pixel_value", want.pixel_value, o_out_data.pixel_value);
                compare_field("last_rect", 32'(want.last_rect),
                              32'(o_out_data.last_rect));
                rects_checked++;
            end
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        string glyph_set;
        int    sent, word_len, x_pos, y_pos, frame_w, frame_h;
        glyph_set = "abcdefghiklmnoprstuwyABCDEFGHIKLMNOPRSTUVWXY,:'!.-+0123456789";

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: scale 1, no spacing, white, 640 by 480.
        settings_used++;
        queue_char("A", 1'b1, 16'd0, 16'd0);
        queue_char("E", 1'b0, 16'hFFFF, 16'hFFFF);
        queue_char(8'h2B, 1'b0, 16'd0, 16'd0);
        queue_char(8'h00, 1'b0, 16'd0, 16'd0);   // blank, cursor still moves
        queue_char("j", 1'b0, 16'd0, 16'd0);     // no glyph for this letter
        queue_char(8'hFF, 1'b0, 16'd0, 16'd0);
        queue_char("W", 1'b1, -16'sd3, -16'sd2); // cut at the left and bottom
        queue_char("H", 1'b1, 16'd637, 16'd477); // cut at the right and top
        queue_char("O", 1'b1, 16'h7FFF, 16'h7FFF); // wholly off the frame
        queue_char("M", 1'b1, 16'h8000, 16'h8000);
        queue_char(8'h2E, 1'b1, 16'd100, 16'd100);
        queue_char("8", 1'b0, 16'd0, 16'd0);
        queue_char("y", 1'b0, 16'd0, 16'd0);
        queue_char("m", 1'b0, 16'd0, 16'd0);
        drain();

        // Largest cells, widest spacing, black, frame at its limit.
        settings_used++;
        write_reg(sgrg_pkg::CFG_SCALE, 32'd63);
        write_reg(sgrg_pkg::CFG_SPACING, 32'h0000_007F);
        write_reg(sgrg_pkg::CFG_FILL_COLOUR, 32'h0000_0000);
        write_reg(sgrg_pkg::CFG_FRAME_WIDTH, 32'd4096);
        write_reg(sgrg_pkg::CFG_FRAME_HEIGHT, 32'd4096);
        cfg_valid <= 1'b0;
        queue_char("B", 1'b1, 16'd0, 16'd0);
        queue_char("K", 1'b0, 16'd0, 16'd0);
        queue_char("0", 1'b0, 16'd0, 16'd0);
        queue_char("X", 1'b1, 16'd4000, 16'd4000);
        drain();

        // Zero scale drops everything; the frame is oversized, and the
        // indexes past the register list must leave the settings alone.
        settings_used++;
        write_reg(sgrg_pkg::CFG_SCALE, 32'd0);
        write_reg(sgrg_pkg::CFG_SPACING, 32'hFFFF_FF80);
        write_reg(sgrg_pkg::CFG_FRAME_WIDTH, 32'd8191);
        write_reg(sgrg_pkg::CFG_FRAME_HEIGHT, 32'd8191);
        write_reg(3'd5, 32'h0000_0021);
        write_reg(3'd6, 32'hFFFF_FFFF);
        write_reg(3'd7, 32'h0000_0005);
        cfg_valid <= 1'b0;
        queue_char("E", 1'b1, 16'd10, 16'd10);
        queue_char("H", 1'b0, 16'd0, 16'd0);
        drain();

        // A zero-width frame leaves nothing.
        settings_used++;
        write_reg(sgrg_pkg::CFG_SCALE, 32'd1);
        write_reg(sgrg_pkg::CFG_FRAME_WIDTH, 32'd0);
        write_reg(sgrg_pkg::CFG_FRAME_HEIGHT, 32'd100);
        cfg_valid <= 1'b0;
        queue_char("E", 1'b1, 16'd0, 16'd0);
        drain();

        // A one-pixel frame keeps only the corner cell.
        settings_used++;
        write_reg(sgrg_pkg::CFG_SCALE, 32'd2);
        write_reg(sgrg_pkg::CFG_FRAME_WIDTH, 32'd1);
        write_reg(sgrg_pkg::CFG_FRAME_HEIGHT, 32'd1);
        cfg_valid <= 1'b0;
        queue_char("L", 1'b1, 16'd0, 16'd0);
        queue_char("U", 1'b1, 16'd0, 16'd0);
        drain();

        // Random part: strings placed on the frame with random text, mixed
        // with stray requests of arbitrary content.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            settings_used++;
            if (p == PRESSURE_PHASE) begin
                write_reg(sgrg_pkg::CFG_SCALE, 32'd3);
                write_reg(sgrg_pkg::CFG_SPACING, 32'd2);
                write_reg(sgrg_pkg::CFG_FILL_COLOUR, $urandom);
                write_reg(sgrg_pkg::CFG_FRAME_WIDTH, 32'd640);
                write_reg(sgrg_pkg::CFG_FRAME_HEIGHT, 32'd480);
            end else begin
                write_reg(sgrg_pkg::CFG_SCALE, ($urandom_range(0, 3) != 0) ?
                          $urandom_range(1, 6) : $urandom_range(0, 63));
                write_reg(sgrg_pkg::CFG_SPACING, $urandom);
                write_reg(sgrg_pkg::CFG_FILL_COLOUR, $urandom);
                write_reg(sgrg_pkg::CFG_FRAME_WIDTH, pick_frame());
                write_reg(sgrg_pkg::CFG_FRAME_HEIGHT, pick_frame());
            end
            cfg_valid <= 1'b0;
            if (p == PRESSURE_PHASE) long_hold_req <= 1'b1;

            frame_w = (width_reg > FRAME_LIMIT) ? FRAME_LIMIT : width_reg;
            frame_h = (height_reg > FRAME_LIMIT) ? FRAME_LIMIT : height_reg;
            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                if (p != PRESSURE_PHASE && $urandom_range(0, 4) == 0) begin
                    queue_char(8'($urandom), 1'($urandom), 16'($urandom), 16'($urandom));
                    sent++;
                end else begin
                    word_len = $urandom_range(1, 8);
                    x_pos = int'($urandom_range(0, frame_w + 16)) - 12;
                    y_pos = int'($urandom_range(0, frame_h + 16)) - 12;
                    for (int k = 0; k < word_len; k++) begin
                        queue_char(glyph_set[$urandom_range(0, glyph_set.len() - 1)],
                                   k == 0,
                                   (k == 0) ? 16'(x_pos) : 16'($urandom),
                                   (k == 0) ? 16'(y_pos) : 16'($urandom));
                    end
                    sent += word_len;
                end
            end
            drain();
        end

        $display("summary: %0d characters under %0d register settings, %0d writes",
                 chars_accepted, settings_used, reg_writes);
        $display("summary: %0d rectangles compared, %0d mismatches",
                 rects_checked, faults);
        if (faults == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
